// ===== design/lpht_pkg.sv =====
// Shared types and constants of the linear-probing hash table
`timescale 1ns / 1ps
package lpht_pkg;

	localparam int KEY_W    = 32;
	localparam int SLOT_OUT_W = 4;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_FOUND    = 2'd2,
		ST_MISSING  = 2'd3
	} lpht_status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_SEARCH = 1'b1
	} lpht_action_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} lpht_entry_t;

endpackage

// ===== design/linear_probe_hash_table_top.sv =====
// Linear-probing hash table: probe control, slot memory and home-slot unit
//
//  channel | signals                         | transaction moves
//  --------+---------------------------------+---------------------------
//  in      | in_valid, in_ready, action, key | one insert or search request
//  out     | out_valid, out_ready, status,   | one result
//          | slot                            |
//
// One request at a time: a new request is taken only once the result of the last
// one has been handed to the output register. The home slot is the key masked to
// AW bits when TABLE_SLOTS is a power of two, else a registered byte fold,
// reciprocal multiply and subtract. Probing reads one slot a cycle through the
// single memory read port from the home slot on, wrapping, and stops at a hit or
// after all TABLE_SLOTS slots. After reset a clearing pass empties the table; no
// request is taken meanwhile. A held result also holds off the next request.
`timescale 1ns / 1ps
module linear_probe_hash_table_top import lpht_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [KEY_W-1:0]      key,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [SLOT_OUT_W-1:0] slot
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HASH  = 5'b00100,
		S_PROBE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t       state_q;
	logic [AW-1:0] clr_q;
	logic          act_q;
	logic [KEY_W-1:0] key_q;
	logic [AW-1:0] issue_pos_q;
	logic [CW-1:0] issue_cnt_q;
	logic          chk_valid_s1;
	logic          chk_last_s1;
	logic [AW-1:0] chk_pos_s1;
	lpht_status_t  res_status_q;
	logic [AW-1:0] res_slot_q;
	logic          out_valid_q;
	lpht_status_t  out_status_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;

	logic          accept;
	logic          mod_done;
	logic [AW-1:0] home;
	logic          issue;
	logic [AW-1:0] next_pos;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	lpht_entry_t   wr_data;
	lpht_entry_t   rd_data;
	logic          hit;
	logic          finish;
	logic          out_free;
	logic [AW+SLOT_OUT_W-1:0] slot_ext;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign slot      = out_slot_q;
	assign out_free  = !out_valid_q || out_ready;
	assign slot_ext  = {{SLOT_OUT_W{1'b0}}, res_slot_q};

	assign issue    = (state_q == S_PROBE) && (issue_cnt_q != CW'(TABLE_SLOTS));
	assign next_pos = (issue_pos_q == AW'(TABLE_SLOTS - 1)) ? '0 : issue_pos_q + 1'b1;

	always_comb begin
		if (act_q == ACT_INSERT) begin
			hit = !rd_data.valid;
		end else begin
			hit = rd_data.valid && (rd_data.key == key_q);
		end
	end

	assign finish = (state_q == S_PROBE) && chk_valid_s1 && (hit || chk_last_s1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = chk_pos_s1;
		wr_data = '{valid: 1'b1, key: key_q};
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '{valid: 1'b0, key: '0};
		end else if (finish && hit && (act_q == ACT_INSERT)) begin
			wr_en = 1'b1;
		end
	end

	lpht_mod #(
		.DIVISOR (TABLE_SLOTS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key_in (key),
		.done   (mod_done),
		.rem    (home)
	);

	lpht_mem #(
		.DEPTH (TABLE_SLOTS)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (issue_pos_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			chk_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					chk_valid_s1 <= 1'b0;
					if (mod_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (finish) begin
						chk_valid_s1 <= 1'b0;
						state_q      <= S_DONE;
					end else begin
						chk_valid_s1 <= issue;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= key;
		end
		if ((state_q == S_HASH) && mod_done) begin
			issue_pos_q <= home;
			issue_cnt_q <= '0;
		end else if (issue) begin
			issue_pos_q <= next_pos;
			issue_cnt_q <= issue_cnt_q + 1'b1;
			chk_pos_s1  <= issue_pos_q;
			chk_last_s1 <= (issue_cnt_q == CW'(TABLE_SLOTS - 1));
		end
		if (finish) begin
			if (hit) begin
				res_status_q <= (act_q == ACT_INSERT) ? ST_INSERTED : ST_FOUND;
				res_slot_q   <= chk_pos_s1;
			end else begin
				res_status_q <= (act_q == ACT_INSERT) ? ST_FULL : ST_MISSING;
				res_slot_q   <= '0;
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			out_status_q <= res_status_q;
			out_slot_q   <= slot_ext[SLOT_OUT_W-1:0];
		end
	end

endmodule

// ===== design/lpht_mod.sv =====
// Key modulo slot count: mask for a power of two, else byte fold and reciprocal multiply
`timescale 1ns / 1ps
module lpht_mod import lpht_pkg::*; #(
	parameter int DIVISOR = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [KEY_W-1:0]             key_in,
	output logic                         done,
	output logic [$clog2(DIVISOR)-1:0]   rem
);

	localparam int R = $clog2(DIVISOR);
	localparam bit POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

	logic         done_q;
	logic [R-1:0] rem_q;

	assign done = done_q;
	assign rem  = rem_q;

	if (POW2) begin : g_pow2
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				rem_q <= key_in[R-1:0];
			end
		end
	end else begin : g_recip
		localparam int FOLD_W  = R + 10;
		localparam int RECIP_W = FOLD_W + 2;
		localparam int PROD_W  = 2 * FOLD_W + 2;
		localparam int QUOT_W  = FOLD_W - R + 1;
		localparam int SHIFT   = FOLD_W + R;
		localparam logic [FOLD_W-1:0]  C1    = FOLD_W'((64'd1 << 8) % DIVISOR);
		localparam logic [FOLD_W-1:0]  C2    = FOLD_W'((64'd1 << 16) % DIVISOR);
		localparam logic [FOLD_W-1:0]  C3    = FOLD_W'((64'd1 << 24) % DIVISOR);
		localparam logic [FOLD_W-1:0]  DIV_F = FOLD_W'(DIVISOR);
		localparam logic [RECIP_W-1:0] RECIP =
			RECIP_W'(((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR);

		logic              run_s1;
		logic              run_s2;
		logic [FOLD_W-1:0] fold;
		logic [FOLD_W-1:0] fold_s1;
		logic [FOLD_W-1:0] fold_s2;
		logic [PROD_W-1:0] prod;
		logic [QUOT_W-1:0] quot_s2;
		logic [FOLD_W-1:0] diff;

		always_comb begin
			fold = FOLD_W'(key_in[7:0]) + FOLD_W'(key_in[15:8]) * C1
				+ FOLD_W'(key_in[23:16]) * C2 + FOLD_W'(key_in[31:24]) * C3;
			prod = PROD_W'(fold_s1) * PROD_W'(RECIP);
			diff = fold_s2 - FOLD_W'(quot_s2) * DIV_F;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				run_s1 <= 1'b0;
				run_s2 <= 1'b0;
				done_q <= 1'b0;
			end else begin
				run_s1 <= start;
				run_s2 <= run_s1;
				done_q <= run_s2;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				fold_s1 <= fold;
			end
			if (run_s1) begin
				fold_s2 <= fold_s1;
				quot_s2 <= prod[SHIFT +: QUOT_W];
			end
			if (run_s2) begin
				rem_q <= diff[R-1:0];
			end
		end
	end

endmodule

// ===== design/lpht_mem.sv =====
// Slot memory: one write port, one read port with registered data
`timescale 1ns / 1ps
module lpht_mem import lpht_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  lpht_entry_t              wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output lpht_entry_t              rd_data
);

	lpht_entry_t mem [DEPTH];
	lpht_entry_t rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule
